// File: rtl/nla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nla_pkg
// Shared types and constants for the nearest landmark association block.
// ----------------------------------------------------------------------------
package nla_pkg;

    // fixed field widths
    localparam int KIND_WIDTH = 2;
    localparam int ID_WIDTH   = 16;

    // request kinds
    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    // top level sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH1,
        ST_FLUSH2,
        ST_FINISH
    } state_t;

    // per cell control
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    // distance unit control
    typedef struct packed {
        logic start;
        logic tap_valid;
    } dist_ctrl_t;

endpackage

// File: rtl/nla_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nla_req_if
// Request channel: clear, append or query word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nla_req_if #(
    parameter int COORD_WIDTH = 24
);
    logic                                valid;
    logic                                ready;
    logic [nla_pkg::KIND_WIDTH-1:0]      kind;
    logic [nla_pkg::ID_WIDTH-1:0]        landmark_id;
    logic signed [COORD_WIDTH-1:0]       pos_x;
    logic signed [COORD_WIDTH-1:0]       pos_y;

    modport source (
        output valid,
        output kind,
        output landmark_id,
        output pos_x,
        output pos_y,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  landmark_id,
        input  pos_x,
        input  pos_y,
        output ready
    );
endinterface

// File: rtl/nla_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nla_rsp_if
// Response channel: nearest landmark id and status flags per query.
// ----------------------------------------------------------------------------
interface nla_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [nla_pkg::ID_WIDTH-1:0]    matched_id;
    logic                            found;
    logic                            table_overflowed;

    modport source (
        output valid,
        output matched_id,
        output found,
        output table_overflowed,
        input  ready
    );

    modport sink (
        input  valid,
        input  matched_id,
        input  found,
        input  table_overflowed,
        output ready
    );
endinterface

// File: rtl/nla_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nla_cell
// One landmark slot of the ring: loads on append, passes its entry to the
// neighbouring cell on every scan cycle.
// ----------------------------------------------------------------------------
module nla_cell #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                              clk,
    input  nla_pkg::cell_ctrl_t               ctrl,
    input  logic [nla_pkg::ID_WIDTH-1:0]      load_id,
    input  logic signed [COORD_WIDTH-1:0]     load_x,
    input  logic signed [COORD_WIDTH-1:0]     load_y,
    input  logic [nla_pkg::ID_WIDTH-1:0]      nbr_id,
    input  logic signed [COORD_WIDTH-1:0]     nbr_x,
    input  logic signed [COORD_WIDTH-1:0]     nbr_y,
    output logic [nla_pkg::ID_WIDTH-1:0]      id,
    output logic signed [COORD_WIDTH-1:0]     x,
    output logic signed [COORD_WIDTH-1:0]     y
);

    logic [nla_pkg::ID_WIDTH-1:0]  id_reg;
    logic signed [COORD_WIDTH-1:0] x_reg;
    logic signed [COORD_WIDTH-1:0] y_reg;

    // entry storage, no reset on payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            id_reg <= load_id;
            x_reg  <= load_x;
            y_reg  <= load_y;
        end
        else if (ctrl.shift)
        begin
            id_reg <= nbr_id;
            x_reg  <= nbr_x;
            y_reg  <= nbr_y;
        end
    end

    assign id = id_reg;
    assign x  = x_reg;
    assign y  = y_reg;

endmodule

// File: rtl/nla_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nla_dist
// Squared distance pipeline at the head of the ring: absolute differences,
// squares, then sum and compare against the running best.
// ----------------------------------------------------------------------------
module nla_dist #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  nla_pkg::dist_ctrl_t               ctrl,
    input  logic [nla_pkg::ID_WIDTH-1:0]      tap_id,
    input  logic signed [COORD_WIDTH-1:0]     tap_x,
    input  logic signed [COORD_WIDTH-1:0]     tap_y,
    input  logic signed [COORD_WIDTH-1:0]     obs_x,
    input  logic signed [COORD_WIDTH-1:0]     obs_y,
    output logic                              found,
    output logic [nla_pkg::ID_WIDTH-1:0]      best_id
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int SQ_W   = 2 * COORD_WIDTH;
    localparam int SUM_W  = SQ_W + 1;

    logic signed [DIFF_W-1:0]     diff_x;
    logic signed [DIFF_W-1:0]     diff_y;
    logic signed [DIFF_W-1:0]     neg_x;
    logic signed [DIFF_W-1:0]     neg_y;
    logic [COORD_WIDTH-1:0]       abs_x;
    logic [COORD_WIDTH-1:0]       abs_y;
    logic [SUM_W-1:0]             sum;
    logic                         better;

    logic                         s1_valid_reg;
    logic [nla_pkg::ID_WIDTH-1:0] s1_id_reg;
    logic [COORD_WIDTH-1:0]       s1_dx_reg;
    logic [COORD_WIDTH-1:0]       s1_dy_reg;
    logic                         s2_valid_reg;
    logic [nla_pkg::ID_WIDTH-1:0] s2_id_reg;
    logic [SQ_W-1:0]              s2_sx_reg;
    logic [SQ_W-1:0]              s2_sy_reg;
    logic                         have_reg;
    logic [nla_pkg::ID_WIDTH-1:0] best_id_reg;
    logic [SUM_W-1:0]             best_dist_reg;

    // absolute differences, magnitude always fits the coordinate width
    always_comb
    begin
        diff_x = {obs_x[COORD_WIDTH-1], obs_x} - {tap_x[COORD_WIDTH-1], tap_x};
        diff_y = {obs_y[COORD_WIDTH-1], obs_y} - {tap_y[COORD_WIDTH-1], tap_y};
        neg_x  = -diff_x;
        neg_y  = -diff_y;
        abs_x  = diff_x[DIFF_W-1] ? neg_x[COORD_WIDTH-1:0] : diff_x[COORD_WIDTH-1:0];
        abs_y  = diff_y[DIFF_W-1] ? neg_y[COORD_WIDTH-1:0] : diff_y[COORD_WIDTH-1:0];
    end

    // sum of squares and strict less-than against the best so far
    always_comb
    begin
        sum    = {1'b0, s2_sx_reg} + {1'b0, s2_sy_reg};
        better = !have_reg || (sum < best_dist_reg);
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctrl.tap_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        s1_id_reg <= tap_id;
        s1_dx_reg <= abs_x;
        s1_dy_reg <= abs_y;
        s2_id_reg <= s1_id_reg;
        s2_sx_reg <= s1_dx_reg * s1_dx_reg;
        s2_sy_reg <= s1_dy_reg * s1_dy_reg;
    end

    // running best, first entry wins a tie
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            have_reg <= 1'b0;
        end
        else if (s2_valid_reg)
        begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && better && !ctrl.start)
        begin
            best_id_reg   <= s2_id_reg;
            best_dist_reg <= sum;
        end
    end

    assign found   = have_reg;
    assign best_id = have_reg ? best_id_reg : '0;

endmodule

// File: rtl/nearest_landmark_association.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_landmark_association
// Landmark table held in a ring of cells; a query rotates the ring once
// through a squared distance pipeline and returns the nearest landmark id.
// ----------------------------------------------------------------------------
// clear and append words give no response
// query: the ring rotates one cell per cycle in SCAN, then FLUSH1 and FLUSH2
//   drain the three stage distance pipeline; FINISH registers the response
//   and waits while a response is still held; requests are taken only in IDLE
// reset: entry count and overflow flag cleared, table contents undefined
// ----------------------------------------------------------------------------
module nearest_landmark_association #(
    parameter int MAX_LANDMARKS = 64,
    parameter int COORD_WIDTH   = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    nla_req_if.sink    req,
    nla_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(MAX_LANDMARKS + 1);

    nla_pkg::state_t               state_reg;
    nla_pkg::state_t               state_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          overflow_reg;
    logic                          overflow_next;
    logic [CNT_W-1:0]              scan_reg;
    logic [CNT_W-1:0]              scan_next;
    logic signed [COORD_WIDTH-1:0] obs_x_reg;
    logic signed [COORD_WIDTH-1:0] obs_x_next;
    logic signed [COORD_WIDTH-1:0] obs_y_reg;
    logic signed [COORD_WIDTH-1:0] obs_y_next;
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    logic [nla_pkg::ID_WIDTH-1:0]  rsp_id_reg;
    logic [nla_pkg::ID_WIDTH-1:0]  rsp_id_next;
    logic                          rsp_found_reg;
    logic                          rsp_found_next;
    logic                          rsp_ovf_reg;
    logic                          rsp_ovf_next;

    logic                          req_fire;
    logic                          append_go;
    nla_pkg::dist_ctrl_t           dist_ctrl;
    logic                          best_found;
    logic [nla_pkg::ID_WIDTH-1:0]  best_id;

    logic [nla_pkg::ID_WIDTH-1:0]  cell_id [MAX_LANDMARKS];
    logic signed [COORD_WIDTH-1:0] cell_x  [MAX_LANDMARKS];
    logic signed [COORD_WIDTH-1:0] cell_y  [MAX_LANDMARKS];

    assign req_fire  = req.valid && req.ready;
    assign append_go = req_fire && (req.kind == nla_pkg::KIND_APPEND)
                       && (count_reg < CNT_W'(MAX_LANDMARKS));

    // ring of landmark cells, cell 0 feeds the distance pipeline
    for (genvar i = 0; i < MAX_LANDMARKS; i++)
    begin : g_cell
        localparam int NEXT = (i + 1) % MAX_LANDMARKS;
        nla_pkg::cell_ctrl_t ctrl;

        assign ctrl = '{
            load:  append_go && (count_reg == CNT_W'(i)),
            shift: (state_reg == nla_pkg::ST_SCAN)
        };

        nla_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .load_id (req.landmark_id),
            .load_x  (req.pos_x),
            .load_y  (req.pos_y),
            .nbr_id  (cell_id[NEXT]),
            .nbr_x   (cell_x[NEXT]),
            .nbr_y   (cell_y[NEXT]),
            .id      (cell_id[i]),
            .x       (cell_x[i]),
            .y       (cell_y[i])
        );
    end

    // distance and best tracking
    nla_dist #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (dist_ctrl),
        .tap_id  (cell_id[0]),
        .tap_x   (cell_x[0]),
        .tap_y   (cell_y[0]),
        .obs_x   (obs_x_reg),
        .obs_y   (obs_y_reg),
        .found   (best_found),
        .best_id (best_id)
    );

    // sequencer next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        scan_next      = scan_reg;
        obs_x_next     = obs_x_reg;
        obs_y_next     = obs_y_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_id_next    = rsp_id_reg;
        rsp_found_next = rsp_found_reg;
        rsp_ovf_next   = rsp_ovf_reg;
        dist_ctrl      = '0;

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            nla_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req.kind)
                        nla_pkg::KIND_CLEAR:
                        begin
                            count_next    = '0;
                            overflow_next = 1'b0;
                        end
                        nla_pkg::KIND_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_LANDMARKS))
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        nla_pkg::KIND_QUERY:
                        begin
                            obs_x_next      = req.pos_x;
                            obs_y_next      = req.pos_y;
                            scan_next       = '0;
                            dist_ctrl.start = 1'b1;
                            state_next      = nla_pkg::ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            nla_pkg::ST_SCAN:
            begin
                dist_ctrl.tap_valid = (scan_reg < count_reg);
                if (scan_reg == CNT_W'(MAX_LANDMARKS - 1))
                begin
                    state_next = nla_pkg::ST_FLUSH1;
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            nla_pkg::ST_FLUSH1:
            begin
                state_next = nla_pkg::ST_FLUSH2;
            end
            nla_pkg::ST_FLUSH2:
            begin
                state_next = nla_pkg::ST_FINISH;
            end
            nla_pkg::ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_id_next    = best_id;
                    rsp_found_next = best_found;
                    rsp_ovf_next   = overflow_reg;
                    state_next     = nla_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nla_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nla_pkg::ST_IDLE;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            scan_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            scan_reg      <= scan_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        obs_x_reg     <= obs_x_next;
        obs_y_reg     <= obs_y_next;
        rsp_id_reg    <= rsp_id_next;
        rsp_found_reg <= rsp_found_next;
        rsp_ovf_reg   <= rsp_ovf_next;
    end

    // channel outputs
    assign req.ready            = (state_reg == nla_pkg::ST_IDLE);
    assign rsp.valid            = rsp_valid_reg;
    assign rsp.matched_id       = rsp_id_reg;
    assign rsp.found            = rsp_found_reg;
    assign rsp.table_overflowed = rsp_ovf_reg;

endmodule
